// File: src/gvv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvv_pkg
// Shared types and constants for the ghost virtual velocity unit.
// ----------------------------------------------------------------------------
package gvv_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REAL_DIST = 2'd1;

    localparam int VEL_W  = 32;
    localparam int DIST_W = 31;

    // sideband that rides along the geometry pipeline
    typedef struct packed {
        logic              bypass;
        logic [VEL_W-1:0]  vel_x;
        logic [VEL_W-1:0]  vel_y;
        logic [DIST_W-1:0] dreal;
    } side_t;

    typedef struct packed {
        logic             bypass;
        logic             neg;
        logic [VEL_W-1:0] vel;
    } xside_t;

    typedef struct packed {
        logic             neg;
        logic [VEL_W-1:0] vel;
    } yside_t;

endpackage
`default_nettype wire

// File: src/ghost_virtual_velocity_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ghost_virtual_velocity_unit
// No-slip virtual velocity for ghost particles, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one particle pair per item, m_* one velocity result per item.
//   cfg_* writes virtual_mode (index 0) and min_real_distance (index 1);
//   cfg_ready is always high, writes belong to idle periods.
//   Throughput is one item per cycle while the output is not stalled. An item
//   passes stages A to E, the 128-stage distance divider, the 64-stage square
//   root, stage F, the 65-stage velocity dividers and the output register.
//   Pass-through items take the same path, so order is kept.
//   The whole pipeline advances on one enable: it moves whenever the output
//   register is empty or being taken. While m_tready is low with a result
//   waiting, s_tready drops and every stage holds.
//   Reset clears all valid bits, virtual_mode to 0 and min_real_distance to
//   1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ghost_virtual_velocity_unit
    import gvv_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // ghost_x, ghost_y, line_origin_x, line_origin_y, line_dir_x, line_dir_y,
    // real_distance(31), real_vel_x, real_vel_y, dest_vel_x, dest_vel_y, pad
    input  wire logic [351:0]         s_tdata,
    // ghost_flag
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_vel_x, out_vel_y
    output logic [63:0]               m_tdata,
    // was_saturated
    output logic                      m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIST_W-1:0]    cfg_data
);

    localparam int SIDE_W = $bits(side_t);

    logic              ce;
    logic              mode_reg;
    logic [DIST_W-1:0] min_dist_reg;

    assign cfg_ready = 1'b1;
    assign ce        = !m_tvalid || m_tready;
    assign s_tready  = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            min_dist_reg <= DIST_W'(1) << FRAC_BITS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VIRTUAL_MODE:  mode_reg     <= cfg_data[0];
                CFG_MIN_REAL_DIST: min_dist_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input unpack
    logic signed [31:0] in_gx, in_gy, in_ox, in_oy, in_dx, in_dy;
    logic        [30:0] in_rd;
    logic signed [31:0] in_rvx, in_rvy, in_dvx, in_dvy;
    logic        [30:0] in_dreal;
    side_t              in_side;

    assign in_gx  = s_tdata[31:0];
    assign in_gy  = s_tdata[63:32];
    assign in_ox  = s_tdata[95:64];
    assign in_oy  = s_tdata[127:96];
    assign in_dx  = s_tdata[159:128];
    assign in_dy  = s_tdata[191:160];
    assign in_rd  = s_tdata[222:192];
    assign in_rvx = s_tdata[254:223];
    assign in_rvy = s_tdata[286:255];
    assign in_dvx = s_tdata[318:287];
    assign in_dvy = s_tdata[350:319];

    always_comb
    begin
        in_dreal = (in_rd < min_dist_reg) ? min_dist_reg : in_rd;
        if (in_dreal == '0)
        begin
            in_dreal = DIST_W'(1);
        end
        in_side.bypass = !(s_tuser && mode_reg);
        in_side.vel_x  = in_side.bypass ? in_dvx : in_rvx;
        in_side.vel_y  = in_side.bypass ? in_dvy : in_rvy;
        in_side.dreal  = in_dreal;
    end

    // stage A: relative position
    logic               a_v_reg;
    logic signed [32:0] a_px_reg, a_py_reg;
    logic signed [31:0] a_dx_reg, a_dy_reg;
    side_t              a_side_reg;
    // stage B: products
    logic               b_v_reg;
    logic signed [64:0] b_t1_reg, b_t2_reg;
    logic signed [63:0] b_nx_reg, b_ny_reg;
    logic signed [65:0] b_qx_reg, b_qy_reg;
    side_t              b_side_reg;
    // stage C: cross magnitude, norm, point distance squared
    logic               c_v_reg;
    logic        [63:0] c_c_reg, c_n_reg;
    logic        [65:0] c_psq_reg;
    side_t              c_side_reg;
    logic signed [65:0] c_diff;
    logic signed [65:0] c_abs;
    // stage D: partial squares of the cross term
    logic               d_v_reg;
    logic        [63:0] d_hh_reg, d_hl_reg, d_ll_reg, d_n_reg;
    logic        [65:0] d_psq_reg;
    side_t              d_side_reg;
    // stage E: divider operands
    logic               e_v_reg;
    logic       [127:0] e_num_reg;
    logic        [63:0] e_den_reg;
    side_t              e_side_reg;
    logic       [127:0] e_c2;

    assign c_diff = 66'(b_t1_reg) - 66'(b_t2_reg);
    assign c_abs  = c_diff[65] ? -c_diff : c_diff;
    assign e_c2   = {d_hh_reg, 64'd0} + {31'd0, d_hl_reg, 33'd0} + {64'd0, d_ll_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_px_reg   <= 33'(in_gx) - 33'(in_ox);
            a_py_reg   <= 33'(in_gy) - 33'(in_oy);
            a_dx_reg   <= in_dx;
            a_dy_reg   <= in_dy;
            a_side_reg <= in_side;

            b_t1_reg   <= 65'(a_px_reg) * 65'(a_dy_reg);
            b_t2_reg   <= 65'(a_py_reg) * 65'(a_dx_reg);
            b_nx_reg   <= 64'(a_dx_reg) * 64'(a_dx_reg);
            b_ny_reg   <= 64'(a_dy_reg) * 64'(a_dy_reg);
            b_qx_reg   <= 66'(a_px_reg) * 66'(a_px_reg);
            b_qy_reg   <= 66'(a_py_reg) * 66'(a_py_reg);
            b_side_reg <= a_side_reg;

            c_c_reg    <= c_abs[63:0];
            c_n_reg    <= $unsigned(b_nx_reg + b_ny_reg);
            c_psq_reg  <= $unsigned(b_qx_reg + b_qy_reg);
            c_side_reg <= b_side_reg;

            d_hh_reg   <= 64'(c_c_reg[63:32]) * 64'(c_c_reg[63:32]);
            d_hl_reg   <= 64'(c_c_reg[63:32]) * 64'(c_c_reg[31:0]);
            d_ll_reg   <= 64'(c_c_reg[31:0]) * 64'(c_c_reg[31:0]);
            d_n_reg    <= c_n_reg;
            d_psq_reg  <= c_psq_reg;
            d_side_reg <= c_side_reg;

            // zero direction: squared point distance, divide by one
            e_num_reg  <= (d_n_reg == '0) ? {62'd0, d_psq_reg} : e_c2;
            e_den_reg  <= (d_n_reg == '0) ? 64'd1 : d_n_reg;
            e_side_reg <= d_side_reg;
        end
    end

    logic              dv_v;
    logic [127:0]      dv_q;
    logic [SIDE_W-1:0] dv_side;

    gvv_pdiv #(
        .NUM_W  (128),
        .DEN_W  (64),
        .SIDE_W (SIDE_W)
    ) u_dist_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (e_v_reg),
        .num       (e_num_reg),
        .den       (e_den_reg),
        .side_in   (e_side_reg),
        .out_valid (dv_v),
        .quo       (dv_q),
        .side_out  (dv_side)
    );

    logic              sq_v;
    logic [63:0]       sq_root;
    logic [SIDE_W-1:0] sq_side_bits;
    side_t             sq_side;

    gvv_psqrt #(
        .RAD_W  (128),
        .SIDE_W (SIDE_W)
    ) u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (dv_v),
        .rad       (dv_q),
        .side_in   (dv_side),
        .out_valid (sq_v),
        .root      (sq_root),
        .side_out  (sq_side_bits)
    );

    assign sq_side = side_t'(sq_side_bits);

    // stage F: d * |U|
    logic               f_v_reg;
    logic        [64:0] f_px_reg, f_py_reg;
    logic        [30:0] f_dreal_reg;
    xside_t             f_xs_reg;
    yside_t             f_ys_reg;
    logic        [31:0] f_mx, f_my;

    assign f_mx = sq_side.vel_x[31] ? -sq_side.vel_x : sq_side.vel_x;
    assign f_my = sq_side.vel_y[31] ? -sq_side.vel_y : sq_side.vel_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            f_v_reg <= sq_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // distance is below 2^33 for any input
            f_px_reg        <= 65'(sq_root[32:0]) * 65'(f_mx);
            f_py_reg        <= 65'(sq_root[32:0]) * 65'(f_my);
            f_dreal_reg     <= sq_side.dreal;
            f_xs_reg.bypass <= sq_side.bypass;
            f_xs_reg.neg    <= !sq_side.vel_x[31] && (sq_side.vel_x != '0);
            f_xs_reg.vel    <= sq_side.vel_x;
            f_ys_reg.neg    <= !sq_side.vel_y[31] && (sq_side.vel_y != '0);
            f_ys_reg.vel    <= sq_side.vel_y;
        end
    end

    logic                   lx_v, ly_v;
    logic [64:0]            lx_q, ly_q;
    logic [$bits(xside_t)-1:0] lx_bits;
    logic [$bits(yside_t)-1:0] ly_bits;
    xside_t                 lx_side;
    yside_t                 ly_side;

    gvv_pdiv #(
        .NUM_W  (65),
        .DEN_W  (DIST_W),
        .SIDE_W ($bits(xside_t))
    ) u_vel_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_v_reg),
        .num       (f_px_reg),
        .den       (f_dreal_reg),
        .side_in   (f_xs_reg),
        .out_valid (lx_v),
        .quo       (lx_q),
        .side_out  (lx_bits)
    );

    gvv_pdiv #(
        .NUM_W  (65),
        .DEN_W  (DIST_W),
        .SIDE_W ($bits(yside_t))
    ) u_vel_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (f_v_reg),
        .num       (f_py_reg),
        .den       (f_dreal_reg),
        .side_in   (f_ys_reg),
        .out_valid (ly_v),
        .quo       (ly_q),
        .side_out  (ly_bits)
    );

    assign lx_side = xside_t'(lx_bits);
    assign ly_side = yside_t'(ly_bits);

    // saturate, apply sign, select pass-through
    logic [31:0] lim_x, lim_y, m_x, m_y, fin_x, fin_y;
    logic        sat_x, sat_y, fin_sat;

    always_comb
    begin
        lim_x   = lx_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        lim_y   = ly_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat_x   = lx_q > {33'd0, lim_x};
        sat_y   = ly_q > {33'd0, lim_y};
        m_x     = sat_x ? lim_x : lx_q[31:0];
        m_y     = sat_y ? lim_y : ly_q[31:0];
        fin_x   = lx_side.neg ? -m_x : m_x;
        fin_y   = ly_side.neg ? -m_y : m_y;
        fin_sat = sat_x || sat_y;
        if (lx_side.bypass)
        begin
            fin_x   = lx_side.vel;
            fin_y   = ly_side.vel;
            fin_sat = 1'b0;
        end
    end

    logic        out_v_reg;
    logic [63:0] out_data_reg;
    logic        out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_v_reg <= lx_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= {fin_y, fin_x};
            out_sat_reg  <= fin_sat;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        lx_v == ly_v)
        else $error("velocity lanes out of step");

    a_bypass_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (lx_v && lx_side.bypass) |-> !fin_sat)
        else $error("saturation flagged on pass-through item");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(lx_v))
        else $error("result without pipeline item");

endmodule
`default_nettype wire

// File: src/gvv_pdiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvv_pdiv
// Pipelined restoring divider, one quotient bit per stage, NUM_W stages.
// ----------------------------------------------------------------------------
module gvv_pdiv #(
    parameter int NUM_W  = 128,
    parameter int DEN_W  = 64,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       quo,
    output logic [SIDE_W-1:0]      side_out
);

    logic              v_reg    [1:NUM_W];
    logic [DEN_W-1:0]  rem_reg  [1:NUM_W];
    logic [NUM_W-1:0]  q_reg    [1:NUM_W];
    logic [DEN_W-1:0]  den_reg  [1:NUM_W];
    logic [SIDE_W-1:0] side_reg [1:NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic              cur_v;
        logic [DEN_W-1:0]  cur_rem;
        logic [NUM_W-1:0]  cur_q;
        logic [DEN_W-1:0]  cur_den;
        logic [SIDE_W-1:0] cur_side;
        logic [DEN_W:0]    sh;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (i == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_rem  = '0;
            assign cur_q    = num;
            assign cur_den  = den;
            assign cur_side = side_in;
        end
        else begin : g_next
            assign cur_v    = v_reg[i];
            assign cur_rem  = rem_reg[i];
            assign cur_q    = q_reg[i];
            assign cur_den  = den_reg[i];
            assign cur_side = side_reg[i];
        end

        assign sh   = {cur_rem, cur_q[NUM_W-1]};
        assign diff = sh - {1'b0, cur_den};
        assign ge   = (sh >= {1'b0, cur_den});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[i+1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i+1]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                q_reg[i+1]    <= {cur_q[NUM_W-2:0], ge};
                den_reg[i+1]  <= cur_den;
                side_reg[i+1] <= cur_side;
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign quo       = q_reg[NUM_W];
    assign side_out  = side_reg[NUM_W];

endmodule
`default_nettype wire

// File: src/gvv_psqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gvv_psqrt
// Pipelined integer square root, one root bit per stage, RAD_W/2 stages.
// ----------------------------------------------------------------------------
module gvv_psqrt #(
    parameter int RAD_W  = 128,
    parameter int SIDE_W = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire logic [RAD_W-1:0]  rad,
    input  wire logic [SIDE_W-1:0] side_in,
    output logic                   out_valid,
    output logic [RAD_W/2-1:0]     root,
    output logic [SIDE_W-1:0]      side_out
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              v_reg    [1:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [1:ROOT_W];
    logic [ROOT_W-1:0] root_reg [1:ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [1:ROOT_W];
    logic [SIDE_W-1:0] side_reg [1:ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic              cur_v;
        logic [REM_W-1:0]  cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [RAD_W-1:0]  cur_rad;
        logic [SIDE_W-1:0] cur_side;
        logic [REM_W+1:0]  sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (i == 0) begin : g_first
            assign cur_v    = in_valid;
            assign cur_rem  = '0;
            assign cur_root = '0;
            assign cur_rad  = rad;
            assign cur_side = side_in;
        end
        else begin : g_next
            assign cur_v    = v_reg[i];
            assign cur_rem  = rem_reg[i];
            assign cur_root = root_reg[i];
            assign cur_rad  = rad_reg[i];
            assign cur_side = side_reg[i];
        end

        assign sh    = {cur_rem, cur_rad[RAD_W-1 -: 2]};
        assign trial = {2'b00, cur_root, 2'b01};
        assign diff  = sh - trial;
        assign ge    = (sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[i+1] <= cur_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[i+1]  <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
                root_reg[i+1] <= {cur_root[ROOT_W-2:0], ge};
                rad_reg[i+1]  <= {cur_rad[RAD_W-3:0], 2'b00};
                side_reg[i+1] <= cur_side;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign side_out  = side_reg[ROOT_W];

endmodule
`default_nettype wire
